// File: hdl/pairwise_ibs_count_accumulator_assert.svh
// ----------------------------------------------------------------------------
// pairwise ibs count accumulator - assertion macros
// shorthand for the concurrent checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_IBS_COUNT_ACCUMULATOR_ASSERT_SVH
`define PAIRWISE_IBS_COUNT_ACCUMULATOR_ASSERT_SVH

// same-cycle implication, masked during reset
`define PIBS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pibs same-cycle check failed");

// next-cycle implication, masked during reset
`define PIBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pibs next-cycle check failed");

`endif

// File: hdl/pibs_pkg.sv
// ----------------------------------------------------------------------------
// pibs_pkg
// word types, codes and site classification for the pairwise ibs counters
// ----------------------------------------------------------------------------
`default_nettype none

package pibs_pkg;

  localparam int CountW  = 31;
  localparam int SampleW = 6;
  localparam int AlleleW = 8;

  localparam logic [AlleleW-1:0] MissingCode = 8'd255;
  localparam logic [CountW-1:0]  CountMax    = {CountW{1'b1}};

  localparam logic OpAccumulate = 1'b0;
  localparam logic OpRead       = 1'b1;

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_ONE     = 2'd1,
    CLS_TWO     = 2'd2,
    CLS_MISSING = 2'd3
  } site_class_t;

  typedef struct packed {
    logic               op;
    logic [SampleW-1:0] sample_first;
    logic [SampleW-1:0] sample_second;
    logic [AlleleW-1:0] allele_a1;
    logic [AlleleW-1:0] allele_a2;
    logic [AlleleW-1:0] allele_b1;
    logic [AlleleW-1:0] allele_b2;
  } in_word_t;

  typedef struct packed {
    logic [CountW-1:0] count_none_shared;
    logic [CountW-1:0] count_one_shared;
    logic [CountW-1:0] count_two_shared;
    logic [CountW-1:0] count_missing;
  } out_word_t;

  function automatic site_class_t classify(input logic [AlleleW-1:0] a1,
                                           input logic [AlleleW-1:0] a2,
                                           input logic [AlleleW-1:0] b1,
                                           input logic [AlleleW-1:0] b2);
    logic               a1m, a2m, b1m, b2m;
    logic [AlleleW-1:0] known;
    logic [1:0]         shared;
    site_class_t        cls;
    a1m = (a1 == MissingCode);
    a2m = (a2 == MissingCode);
    b1m = (b1 == MissingCode);
    b2m = (b2 == MissingCode);
    shared = 2'd0;
    known  = '0;
    cls    = CLS_NONE;
    if ((a1m && a2m) || (b1m && b2m)) begin
      cls = CLS_MISSING;
    end else if (a1m || a2m) begin
      known = a1m ? a2 : a1;
      cls = ((!b1m && known == b1) || (!b2m && known == b2)) ? CLS_ONE : CLS_NONE;
    end else if (b1m || b2m) begin
      known = b1m ? b2 : b1;
      cls = (known == a1 || known == a2) ? CLS_ONE : CLS_NONE;
    end else begin
      if (a1 == b1 || a1 == b2) shared = shared + 2'd1;
      if (a2 == b1 || a2 == b2) shared = shared + 2'd1;
      // homozygote against heterozygote caps at one
      if (shared == 2'd2 && ((a1 == a2) != (b1 == b2))) shared = 2'd1;
      cls = site_class_t'(shared);
    end
    return cls;
  endfunction

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] count);
    return (count == CountMax) ? count : count + CountW'(1);
  endfunction

endpackage

`default_nettype wire

// File: hdl/pibs_ram.sv
// ----------------------------------------------------------------------------
// pibs_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module pibs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AddrW-1:0] rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hdl/pairwise_ibs_count_accumulator.sv
// ----------------------------------------------------------------------------
// pairwise_ibs_count_accumulator
// per-pair ibs0/ibs1/ibs2/missing counters held in one ram, updated by
// read-modify-write with forwarding of the last write
// ----------------------------------------------------------------------------
//  channel | signals                    | word
//  --------+----------------------------+-----------------------------------
//  in      | in_valid, in_ready         | in_word  (op, pair, four alleles)
//  out     | out_valid, out_ready       | out_word (four 31-bit counts)
//  cfg     | cfg_valid, cfg_ready       | cfg_data (total_sites)
//
//  one word a cycle while in_ready is high: stage 0 classifies and issues
//  the ram read, stage 1 updates and writes back; a read word is registered
//  in stage 1, then in the output buffer. after reset a clearing pass zeroes
//  all MAX_SAMPLES*MAX_SAMPLES words, in_ready low; cfg is always taken.
//  a two-word output buffer absorbs out_ready stalls; in_ready drops when it
//  cannot take the result of a word in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pairwise_ibs_count_accumulator_assert.svh"

module pairwise_ibs_count_accumulator #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire pibs_pkg::in_word_t         in_word,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output pibs_pkg::out_word_t             out_word,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [pibs_pkg::CountW-1:0] cfg_data
);

  localparam int Depth = MAX_SAMPLES * MAX_SAMPLES;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] SampleStride = AW'(MAX_SAMPLES);
  localparam logic [AW-1:0] LastAddr     = AW'(Depth - 1);
  localparam int WordW = $bits(pibs_pkg::out_word_t);

  // configuration
  logic [pibs_pkg::CountW-1:0] total_sites;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_sites <= '0;
    end else if (cfg_valid) begin
      total_sites <= cfg_data;
    end
  end

  // clearing pass
  logic          clearing;
  logic [AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == LastAddr) begin
        clearing <= 1'b0;
      end else begin
        clear_addr <= clear_addr + AW'(1);
      end
    end
  end

  // stage 0: order the pair, classify, issue the read
  logic                         in_accept;
  logic [pibs_pkg::SampleW-1:0] lo, hi;
  logic [AW-1:0]                pair_addr;
  logic                         pair_in_range;

  assign in_accept     = in_valid && in_ready;
  assign lo            = (in_word.sample_first < in_word.sample_second) ?
                         in_word.sample_first : in_word.sample_second;
  assign hi            = (in_word.sample_first < in_word.sample_second) ?
                         in_word.sample_second : in_word.sample_first;
  assign pair_in_range = (32'(hi) < 32'(MAX_SAMPLES));
  assign pair_addr     = AW'(lo) * SampleStride + AW'(hi);

  logic                  s1_valid;
  logic                  s1_op;
  logic [AW-1:0]         s1_addr;
  pibs_pkg::site_class_t s1_cls;
  logic                  s1_in_range;
  logic                  s1_self;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept;
    end
    s1_op       <= in_word.op;
    s1_addr     <= pair_addr;
    s1_cls      <= pibs_pkg::classify(in_word.allele_a1, in_word.allele_a2,
                                      in_word.allele_b1, in_word.allele_b2);
    s1_in_range <= pair_in_range;
    s1_self     <= (lo == hi);
  end

  // counter ram
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WordW-1:0] wr_data;
  logic [WordW-1:0] rd_data;

  pibs_ram #(
    .WIDTH (WordW),
    .DEPTH (Depth)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (pair_addr),
    .rd_data (rd_data)
  );

  // last write, forwarded to a read issued on the same edge
  logic                fwd_valid;
  logic [AW-1:0]       fwd_addr;
  pibs_pkg::out_word_t fwd_data;

  // stage 1: modify and write back
  pibs_pkg::out_word_t counts;
  pibs_pkg::out_word_t updated;
  pibs_pkg::out_word_t s1_result;
  logic                s1_push;

  always_comb begin
    counts  = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : pibs_pkg::out_word_t'(rd_data);
    updated = counts;
    case (s1_cls)
      pibs_pkg::CLS_NONE:    updated.count_none_shared = pibs_pkg::bump(counts.count_none_shared);
      pibs_pkg::CLS_ONE:     updated.count_one_shared  = pibs_pkg::bump(counts.count_one_shared);
      pibs_pkg::CLS_TWO:     updated.count_two_shared  = pibs_pkg::bump(counts.count_two_shared);
      pibs_pkg::CLS_MISSING: updated.count_missing     = pibs_pkg::bump(counts.count_missing);
      default:               updated = counts;
    endcase

    s1_result = '0;
    if (s1_in_range) begin
      if (s1_self) begin
        s1_result.count_two_shared = total_sites;
      end else begin
        s1_result = counts;
      end
    end
  end

  assign s1_push = s1_valid && (s1_op == pibs_pkg::OpRead);
  assign wr_en   = clearing ||
                   (s1_valid && s1_op == pibs_pkg::OpAccumulate && s1_in_range && !s1_self);
  assign wr_addr = clearing ? clear_addr : s1_addr;
  assign wr_data = clearing ? '0 : WordW'(updated);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
    fwd_addr <= wr_addr;
    fwd_data <= pibs_pkg::out_word_t'(wr_data);
  end

  // output buffer: head drives the port, skid takes a word while head stalls
  pibs_pkg::out_word_t skid;
  logic                skid_valid;
  logic                pop;
  logic [1:0]          occupancy;

  assign pop       = out_valid && out_ready;
  assign occupancy = 2'(out_valid) + 2'(skid_valid) + 2'(s1_push) - 2'(pop);
  assign in_ready  = !clearing && (occupancy <= 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_word <= skid;
        if (s1_push) begin
          skid <= s1_result;
        end else begin
          skid_valid <= 1'b0;
        end
      end else if (s1_push) begin
        out_word <= s1_result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (s1_push) begin
      if (!out_valid) begin
        out_word  <= s1_result;
        out_valid <= 1'b1;
      end else begin
        skid       <= s1_result;
        skid_valid <= 1'b1;
      end
    end
  end

  // checks
  `PIBS_ASSERT_SAME(a_no_accept_while_clearing, clk, rst, clearing, !in_ready)
  `PIBS_ASSERT_SAME(a_skid_behind_head, clk, rst, skid_valid, out_valid)
  `PIBS_ASSERT_SAME(a_push_has_room, clk, rst, s1_push && !pop, !(out_valid && skid_valid))
  `PIBS_ASSERT_NEXT(a_accept_reaches_stage1, clk, rst, in_accept, s1_valid)

endmodule

`default_nettype wire

// File: verif/pairwise_ibs_count_checker.sv
// ----------------------------------------------------------------------------
// pairwise ibs count checker
// watches the in, out and cfg channels, keeps its own copy of the per-pair
// counters and total_sites, and compares every out word with the oldest
// predicted read
// ----------------------------------------------------------------------------
module pairwise_ibs_count_checker #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire pibs_pkg::in_word_t          in_word,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire pibs_pkg::out_word_t         out_word,
  input  wire logic                        cfg_valid,
  input  wire logic                        cfg_ready,
  input  wire logic [pibs_pkg::CountW-1:0] cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PairCount = MAX_SAMPLES * MAX_SAMPLES;

  pibs_pkg::out_word_t         pair_tally [PairCount];
  pibs_pkg::out_word_t         read_counts [$];
  logic [pibs_pkg::CountW-1:0] site_total;

  initial begin
    errors   = 0;
    pending  = 0;
    compared = 0;
  end

  function automatic logic [pibs_pkg::CountW-1:0] sat_inc(
      input logic [pibs_pkg::CountW-1:0] v);
    return (&v) ? v : v + pibs_pkg::CountW'(1);
  endfunction

  // shared alleles between the two samples of one site
  function automatic pibs_pkg::site_class_t site_sharing(
      input logic [pibs_pkg::AlleleW-1:0] a1,
      input logic [pibs_pkg::AlleleW-1:0] a2,
      input logic [pibs_pkg::AlleleW-1:0] b1,
      input logic [pibs_pkg::AlleleW-1:0] b2);
    logic       a1k, a2k, b1k, b2k;
    logic       any_hit;
    logic [1:0] hits;
    a1k = (a1 != pibs_pkg::MissingCode);
    a2k = (a2 != pibs_pkg::MissingCode);
    b1k = (b1 != pibs_pkg::MissingCode);
    b2k = (b2 != pibs_pkg::MissingCode);
    if (!(a1k || a2k) || !(b1k || b2k)) return pibs_pkg::CLS_MISSING;
    // a lone known allele on either side: any match between known alleles
    any_hit = (a1k && b1k && a1 == b1) || (a1k && b2k && a1 == b2) ||
              (a2k && b1k && a2 == b1) || (a2k && b2k && a2 == b2);
    if (!(a1k && a2k && b1k && b2k)) begin
      return any_hit ? pibs_pkg::CLS_ONE : pibs_pkg::CLS_NONE;
    end
    hits = 2'(a1 == b1 || a1 == b2) + 2'(a2 == b1 || a2 == b2);
    // homozygote against heterozygote counts as one
    if (hits == 2'd2 && ((a1 == a2) != (b1 == b2))) hits = 2'd1;
    return pibs_pkg::site_class_t'(hits);
  endfunction

  task automatic predict_word(input pibs_pkg::in_word_t w);
    int                  lo, hi, idx;
    logic                in_range;
    pibs_pkg::out_word_t res;
    lo       = int'((w.sample_first < w.sample_second) ? w.sample_first : w.sample_second);
    hi       = int'((w.sample_first < w.sample_second) ? w.sample_second : w.sample_first);
    in_range = (hi < MAX_SAMPLES);
    idx      = in_range ? lo * MAX_SAMPLES + hi : 0;
    if (w.op == pibs_pkg::OpAccumulate) begin
      if (in_range && lo != hi) begin
        case (site_sharing(w.allele_a1, w.allele_a2, w.allele_b1, w.allele_b2))
          pibs_pkg::CLS_NONE: begin
            pair_tally[idx].count_none_shared = sat_inc(pair_tally[idx].count_none_shared);
          end
          pibs_pkg::CLS_ONE: begin
            pair_tally[idx].count_one_shared = sat_inc(pair_tally[idx].count_one_shared);
          end
          pibs_pkg::CLS_TWO: begin
            pair_tally[idx].count_two_shared = sat_inc(pair_tally[idx].count_two_shared);
          end
          default: begin
            pair_tally[idx].count_missing = sat_inc(pair_tally[idx].count_missing);
          end
        endcase
      end
    end else begin
      res = '0;
      if (in_range) begin
        if (lo == hi) res.count_two_shared = site_total;
        else res = pair_tally[idx];
      end
      read_counts.push_back(res);
    end
  endtask

  task automatic check_field(input string name, input logic [pibs_pkg::CountW-1:0] want,
                             input logic [pibs_pkg::CountW-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    pibs_pkg::out_word_t want;
    if (rst) begin
      foreach (pair_tally[i]) pair_tally[i] = '0;
      site_total = '0;
      read_counts.delete();
    end else begin
      // the out word at this edge always belongs to an older read
      if (out_valid && out_ready) begin
        if (read_counts.size() == 0) begin
          errors++;
          $display("%0t: unexpected out word, expected none, actual %h", $time, out_word);
        end else begin
          want = read_counts.pop_front();
          check_field("count_none_shared", want.count_none_shared, out_word.count_none_shared);
          check_field("count_one_shared", want.count_one_shared, out_word.count_one_shared);
          check_field("count_two_shared", want.count_two_shared, out_word.count_two_shared);
          check_field("count_missing", want.count_missing, out_word.count_missing);
          compared++;
        end
      end
      if (cfg_valid && cfg_ready) site_total = cfg_data;
      if (in_valid && in_ready) predict_word(in_word);
    end
    pending = read_counts.size();
  end

endmodule

// File: verif/pairwise_ibs_count_accumulator_test.sv
// ----------------------------------------------------------------------------
// pairwise ibs count accumulator test
// directed sites for every sharing class and the self and swapped pairs,
// then random sites concentrated on a few hot pairs under several
// total_sites settings, with random gaps on the in and out channels
// ----------------------------------------------------------------------------
module pairwise_ibs_count_accumulator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Samples       = 64;
  localparam int PhaseWords    = 200;
  localparam int WatchdogLimit = 20000;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  pibs_pkg::in_word_t          in_word   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  pibs_pkg::out_word_t         out_word;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [pibs_pkg::CountW-1:0] cfg_data  = '0;

  int   errors, pending, compared;
  int   quiet_cycles = 0;
  int   words_sent   = 0;
  int   reads_sent   = 0;
  int   settings     = 0;
  logic no_gaps      = 1'b0;

  pairwise_ibs_count_accumulator #(.MAX_SAMPLES(Samples)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pairwise_ibs_count_checker #(.MAX_SAMPLES(Samples)) scoreboard (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .compared  (compared)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WatchdogLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // out side: a random stall, possibly none, after each accepted word unless no_gaps
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready && !no_gaps) begin
        stall = $urandom_range(0, 4);
        if (stall != 0) begin
          @(negedge clk);
          out_ready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
          @(negedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  function automatic pibs_pkg::in_word_t make_word(input logic op, input int s1, input int s2,
                                                   input int a1, input int a2,
                                                   input int b1, input int b2);
    pibs_pkg::in_word_t w;
    w.op            = op;
    w.sample_first  = pibs_pkg::SampleW'(s1);
    w.sample_second = pibs_pkg::SampleW'(s2);
    w.allele_a1     = pibs_pkg::AlleleW'(a1);
    w.allele_a2     = pibs_pkg::AlleleW'(a2);
    w.allele_b1     = pibs_pkg::AlleleW'(b1);
    w.allele_b2     = pibs_pkg::AlleleW'(b2);
    return w;
  endfunction

  function automatic logic [pibs_pkg::SampleW-1:0] hot_sample();
    case ($urandom_range(0, 5))
      0: return pibs_pkg::SampleW'(0);
      1: return pibs_pkg::SampleW'(1);
      2: return pibs_pkg::SampleW'(2);
      3: return pibs_pkg::SampleW'(31);
      4: return pibs_pkg::SampleW'(32);
      default: return pibs_pkg::SampleW'(63);
    endcase
  endfunction

  // alleles mostly drawn around one base code so that pairs share often
  function automatic logic [pibs_pkg::AlleleW-1:0] pick_allele(
      input logic [pibs_pkg::AlleleW-1:0] base);
    case ($urandom_range(0, 9))
      0: return pibs_pkg::MissingCode;
      1: return pibs_pkg::AlleleW'($urandom);
      2, 3, 4, 5: return base;
      default: return base + pibs_pkg::AlleleW'(1);
    endcase
  endfunction

  task automatic send(input pibs_pkg::in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    if (w.op == pibs_pkg::OpRead) reads_sent++;
  endtask

  // hold the in side until every read word is back and the pipe is empty
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_total(input logic [pibs_pkg::CountW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [pibs_pkg::CountW-1:0]  totals [5];
    logic [pibs_pkg::AlleleW-1:0] base;
    pibs_pkg::in_word_t           w;
    int                           counted;

    totals[0] = pibs_pkg::CountMax;
    totals[1] = pibs_pkg::CountW'($urandom_range(2, 1000));
    totals[2] = '0;
    totals[3] = pibs_pkg::CountW'(1);
    totals[4] = pibs_pkg::CountW'($urandom);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // self pair before any register write
    send(make_word(pibs_pkg::OpRead, 5, 5, 0, 0, 0, 0));
    settle();
    write_total(totals[0]);

    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 1, 2, 3, 4));
    send(make_word(pibs_pkg::OpAccumulate, 63, 0, 1, 2, 2, 3));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 1, 2, 2, 1));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 7, 7, 7, 7));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 7, 7, 7, 8));
    send(make_word(pibs_pkg::OpAccumulate, 63, 0, 8, 7, 7, 7));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 255, 255, 1, 2));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 1, 2, 255, 255));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 255, 3, 3, 4));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 3, 255, 255, 3));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 255, 5, 255, 6));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 0, 254, 254, 255));
    send(make_word(pibs_pkg::OpAccumulate, 0, 63, 0, 0, 255, 1));
    send(make_word(pibs_pkg::OpAccumulate, 9, 9, 1, 1, 1, 1));
    send(make_word(pibs_pkg::OpRead, 63, 0, 0, 0, 0, 0));
    send(make_word(pibs_pkg::OpRead, 0, 63, 0, 0, 0, 0));
    send(make_word(pibs_pkg::OpRead, 9, 9, 0, 0, 0, 0));
    send(make_word(pibs_pkg::OpRead, 1, 2, 0, 0, 0, 0));
    send(make_word(pibs_pkg::OpRead, 63, 63, 0, 0, 0, 0));

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      if (phase != 0) write_total(totals[phase]);
      counted = 0;
      while (counted < PhaseWords) begin
        if (counted % 64 == 0) no_gaps <= ($urandom_range(0, 3) == 0);
        w.op = ($urandom_range(0, 3) == 0) ? pibs_pkg::OpRead : pibs_pkg::OpAccumulate;
        if ($urandom_range(0, 9) < 8) begin
          w.sample_first  = hot_sample();
          w.sample_second = hot_sample();
        end else begin
          w.sample_first  = pibs_pkg::SampleW'($urandom);
          w.sample_second = pibs_pkg::SampleW'($urandom);
        end
        base        = pibs_pkg::AlleleW'($urandom_range(0, 253));
        w.allele_a1 = pick_allele(base);
        w.allele_a2 = pick_allele(base);
        w.allele_b1 = pick_allele(base);
        w.allele_b2 = pick_allele(base);
        send(w);
        if (!(w.op == pibs_pkg::OpAccumulate && w.sample_first == w.sample_second)) begin
          counted++;
        end
        if ($urandom_range(0, 99) == 0) settle();
      end
    end
    settle();

    $display("covered %0d words (%0d reads) over %0d total_sites settings", words_sent,
             reads_sent, settings);
    $display("%0d result words compared, %0d mismatches", compared, errors);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/pibs_pkg.sv
hdl/pibs_ram.sv
hdl/pairwise_ibs_count_accumulator.sv
verif/pairwise_ibs_count_checker.sv
verif/pairwise_ibs_count_accumulator_test.sv
